FILE: design/cia_pkg.sv
`default_nettype none
package cia_pkg;

  // decision codes
  localparam logic [1:0] DEC_KEEP        = 2'd0;
  localparam logic [1:0] DEC_MERGE       = 2'd1;
  localparam logic [1:0] DEC_DROP_FIRST  = 2'd2;
  localparam logic [1:0] DEC_DROP_SECOND = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_SHARED  = 3'd0;
  localparam logic [2:0] REG_SLACK       = 3'd1;
  localparam logic [2:0] REG_BIN_MARGIN  = 3'd2;
  localparam logic [2:0] REG_CELL_ONE    = 3'd3;
  localparam logic [2:0] REG_CELL_TWO    = 3'd4;
  localparam logic [2:0] REG_CELL_THREE  = 3'd5;
  localparam logic [2:0] REG_CELL_FOUR   = 3'd6;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_DIFF    = 4;

  typedef struct packed {
    logic [7:0] min_shared_cells;
    logic [3:0] shared_slack;
    logic [7:0] bin_margin;
    logic [7:0] cell_margin_one;
    logic [7:0] cell_margin_two;
    logic [7:0] cell_margin_three;
    logic [7:0] cell_margin_four;
  } cfg_t;

  // classified pair, as handed from the front to the back
  typedef struct packed {
    logic               in_tree;
    logic [2:0]         diff;
    logic signed [9:0]  d_cells;
    logic signed [5:0]  d_layers;
    logic signed [16:0] d_bins;
    logic signed [5:0]  d_level;
  } cls_t;

endpackage
`default_nettype wire

FILE: design/cia_front.sv
`default_nettype none
module cia_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [79:0]   s_tdata,
  input  wire cia_pkg::cfg_t cfg,
  input  wire logic          q_ready,
  output logic               push,
  output cia_pkg::cls_t      item
);

  logic [8:0]         cells_first;
  logic [8:0]         cells_second;
  logic [4:0]         layers_first;
  logic [4:0]         layers_second;
  logic [15:0]        bins_first;
  logic [15:0]        bins_second;
  logic [4:0]         level_first;
  logic [4:0]         level_second;
  logic [8:0]         shared_cells;
  logic [8:0]         min_cells;
  logic signed [9:0]  diff;
  logic signed [10:0] diff_slack;
  logic               gate;
  logic               diff_ok;

  assign cells_first   = s_tdata[8:0];
  assign cells_second  = s_tdata[17:9];
  assign layers_first  = s_tdata[22:18];
  assign layers_second = s_tdata[27:23];
  assign bins_first    = s_tdata[43:28];
  assign bins_second   = s_tdata[59:44];
  assign level_first   = s_tdata[64:60];
  assign level_second  = s_tdata[69:65];
  assign shared_cells  = s_tdata[78:70];

  always_comb begin
    min_cells  = (cells_first <= cells_second) ? cells_first : cells_second;
    diff       = $signed({1'b0, min_cells}) - $signed({1'b0, shared_cells});
    diff_slack = {diff[9], diff} + $signed({7'b0, cfg.shared_slack});
    gate       = (shared_cells >= {1'b0, cfg.min_shared_cells})
                 && (diff_slack <= $signed({2'b0, shared_cells}));
    // negative or above four differing cells falls through to keep both
    diff_ok    = !diff[9] && (diff[8:3] == 6'd0)
                 && (diff[2:0] <= 3'(cia_pkg::MAX_DIFF));

    item.in_tree  = gate && diff_ok;
    item.diff     = diff[2:0];
    item.d_cells  = $signed({1'b0, cells_first}) - $signed({1'b0, cells_second});
    item.d_layers = $signed({1'b0, layers_first}) - $signed({1'b0, layers_second});
    item.d_bins   = $signed({1'b0, bins_first}) - $signed({1'b0, bins_second});
    item.d_level  = $signed({1'b0, level_first}) - $signed({1'b0, level_second});
  end

  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready;

endmodule
`default_nettype wire

FILE: design/cia_queue.sv
`default_nettype none
module cia_queue #(
  parameter int DEPTH = cia_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cia_pkg::cls_t push_item,
  output logic               in_ready,
  input  wire logic          pop,
  output cia_pkg::cls_t      pop_item,
  output logic               out_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cia_pkg::cls_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign do_push   = push && in_ready;
  assign do_pop    = pop && out_valid;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/cia_back.sv
`default_nettype none
module cia_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cia_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire cia_pkg::cls_t q_item,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata
);

  logic [7:0]         cell_margin;
  logic signed [16:0] bm;
  logic signed [9:0]  cm;
  logic [1:0]         dec;
  logic [2:0]         fake_level;
  logic               stop_scan;

  function automatic logic [1:0] by_sign(input logic is_zero, input logic is_neg);
    logic [1:0] r;
    if (is_zero) r = cia_pkg::DEC_KEEP;
    else if (is_neg) r = cia_pkg::DEC_DROP_FIRST;
    else r = cia_pkg::DEC_DROP_SECOND;
    return r;
  endfunction

  always_comb begin
    unique case (q_item.diff)
      3'd1:    cell_margin = cfg.cell_margin_one;
      3'd2:    cell_margin = cfg.cell_margin_two;
      3'd3:    cell_margin = cfg.cell_margin_three;
      default: cell_margin = cfg.cell_margin_four;
    endcase
    // with no differing cells the strong rule is a plain sign test
    if (q_item.diff == 3'd0) begin
      bm = '0;
      cm = '0;
    end else begin
      bm = $signed({9'b0, cfg.bin_margin});
      cm = $signed({2'b0, cell_margin});
    end

    dec = cia_pkg::DEC_KEEP;
    if (q_item.in_tree) begin
      priority if (q_item.d_bins > bm && q_item.d_cells > cm) begin
        dec = cia_pkg::DEC_DROP_SECOND;
      end else if (q_item.d_bins < -bm && q_item.d_cells < -cm) begin
        dec = cia_pkg::DEC_DROP_FIRST;
      end else if (q_item.d_level != 0) begin
        dec = by_sign(1'b0, q_item.d_level[5]);
      end else if (q_item.diff != 3'd0 && q_item.d_layers != 0) begin
        dec = by_sign(1'b0, q_item.d_layers[5]);
      end else if (q_item.d_bins != 0) begin
        dec = by_sign(1'b0, q_item.d_bins[16]);
      end else if (q_item.d_cells != 0) begin
        dec = by_sign(1'b0, q_item.d_cells[9]);
      end else if (q_item.diff == 3'd0) begin
        dec = cia_pkg::DEC_MERGE;
      end else begin
        dec = cia_pkg::DEC_KEEP;
      end
    end

    fake_level = (dec == cia_pkg::DEC_KEEP) ? 3'd0 : q_item.diff + 3'd1;
    stop_scan  = (dec == cia_pkg::DEC_MERGE) || (dec == cia_pkg::DEC_DROP_SECOND);
  end

  assign pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {2'b00, stop_scan, fake_level, dec};
    end
  end

endmodule
`default_nettype wire

FILE: design/cluster_inclusion_arbiter.sv
`default_nettype none
// channel   dir  handshake            payload
// s_axis    in   s_tvalid/s_tready    one pair of clusters and their shared cells
// m_axis    out  m_tvalid/m_tready    decision, fake level, stop-scan flag
// cfg       in   cfg_we               cfg_index selects the register, cfg_data the value
//
// one item per cycle while m_tready is high; a taken item passes the queue and then
// the output register; the front classifies in the accept cycle and writes the queue,
// the back runs the comparison tree into the output register
// s_tready depends only on queue fill, so it falls only once the queue is full
// synchronous reset empties the queue and output register and loads default margins
module cluster_inclusion_arbiter #(
  parameter int QUEUE_DEPTH = cia_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cells_first, cells_second, layers_first, layers_second, bins_first,
  // bins_second, level_first, level_second, shared_cells
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // decision, fake_level, stop_scan
  output logic [7:0]       m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cia_pkg::cfg_t cfg;
  cia_pkg::cls_t push_item;
  cia_pkg::cls_t pop_item;
  logic          q_ready;
  logic          push;
  logic          q_valid;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_shared_cells  <= 8'd6;
      cfg.shared_slack      <= 4'd2;
      cfg.bin_margin        <= 8'd2;
      cfg.cell_margin_one   <= 8'd4;
      cfg.cell_margin_two   <= 8'd6;
      cfg.cell_margin_three <= 8'd7;
      cfg.cell_margin_four  <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cia_pkg::REG_MIN_SHARED: cfg.min_shared_cells  <= cfg_data;
        cia_pkg::REG_SLACK:      cfg.shared_slack      <= cfg_data[3:0];
        cia_pkg::REG_BIN_MARGIN: cfg.bin_margin        <= cfg_data;
        cia_pkg::REG_CELL_ONE:   cfg.cell_margin_one   <= cfg_data;
        cia_pkg::REG_CELL_TWO:   cfg.cell_margin_two   <= cfg_data;
        cia_pkg::REG_CELL_THREE: cfg.cell_margin_three <= cfg_data;
        cia_pkg::REG_CELL_FOUR:  cfg.cell_margin_four  <= cfg_data;
        default: ;
      endcase
    end
  end

  cia_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .push     (push),
    .item     (push_item)
  );

  cia_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .in_ready  (q_ready),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (q_valid)
  );

  cia_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

FILE: tb/cluster_inclusion_arbiter_tb.sv
`timescale 1ns / 100ps

module cluster_inclusion_arbiter_tb;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 5000;

  // s_tdata layout, last field (cells_first) in the lowest bits
  typedef struct packed {
    logic       pad;
    logic [8:0] shared_cells;
    logic [4:0] level_second;
    logic [4:0] level_first;
    logic [15:0] bins_second;
    logic [15:0] bins_first;
    logic [4:0] layers_second;
    logic [4:0] layers_first;
    logic [8:0] cells_second;
    logic [8:0] cells_first;
  } pair_t;

  typedef struct packed {
    logic [1:0] pad;
    logic       stop_scan;
    logic [2:0] fake_level;
    logic [1:0] decision;
  } verdict_t;

  class arbiter_scoreboard;
    cia_pkg::cfg_t cfg;
    verdict_t verdict_q[$];
    int fails;

    function new();
      cfg.min_shared_cells = 8'd6;
      cfg.shared_slack = 4'd2;
      cfg.bin_margin = 8'd2;
      cfg.cell_margin_one = 8'd4;
      cfg.cell_margin_two = 8'd6;
      cfg.cell_margin_three = 8'd7;
      cfg.cell_margin_four = 8'd8;
      fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        cia_pkg::REG_MIN_SHARED: cfg.min_shared_cells = data;
        cia_pkg::REG_SLACK:      cfg.shared_slack = data[3:0];
        cia_pkg::REG_BIN_MARGIN: cfg.bin_margin = data;
        cia_pkg::REG_CELL_ONE:   cfg.cell_margin_one = data;
        cia_pkg::REG_CELL_TWO:   cfg.cell_margin_two = data;
        cia_pkg::REG_CELL_THREE: cfg.cell_margin_three = data;
        cia_pkg::REG_CELL_FOUR:  cfg.cell_margin_four = data;
        default: ;
      endcase
    endfunction

    // positive favours the earlier cluster
    function logic [1:0] sign_vote(int d);
      if (d > 0) return cia_pkg::DEC_DROP_SECOND;
      if (d < 0) return cia_pkg::DEC_DROP_FIRST;
      return cia_pkg::DEC_KEEP;
    endfunction

    function verdict_t judge(pair_t p);
      int c1, c2, sh, diff, dc, dl, db, dv, bm, cm;
      logic [1:0] dec;
      verdict_t v;
      c1 = int'(p.cells_first);
      c2 = int'(p.cells_second);
      sh = int'(p.shared_cells);
      diff = ((c1 <= c2) ? c1 : c2) - sh;
      dc = c1 - c2;
      dl = int'(p.layers_first) - int'(p.layers_second);
      db = int'(p.bins_first) - int'(p.bins_second);
      dv = int'(p.level_first) - int'(p.level_second);
      dec = cia_pkg::DEC_KEEP;
      if (sh >= int'(cfg.min_shared_cells) && diff + int'(cfg.shared_slack) <= sh) begin
        if (diff == 0) begin
          if (db > 0 && dc > 0) dec = cia_pkg::DEC_DROP_SECOND;
          else if (db < 0 && dc < 0) dec = cia_pkg::DEC_DROP_FIRST;
          else if (dv != 0) dec = sign_vote(dv);
          else if (db != 0) dec = sign_vote(db);
          else if (dc != 0) dec = sign_vote(dc);
          else dec = cia_pkg::DEC_MERGE;
        end else if (diff >= 1 && diff <= cia_pkg::MAX_DIFF) begin
          bm = int'(cfg.bin_margin);
          case (diff)
            1: cm = int'(cfg.cell_margin_one);
            2: cm = int'(cfg.cell_margin_two);
            3: cm = int'(cfg.cell_margin_three);
            default: cm = int'(cfg.cell_margin_four);
          endcase
          if (db > bm && dc > cm) dec = cia_pkg::DEC_DROP_SECOND;
          else if (db < -bm && dc < -cm) dec = cia_pkg::DEC_DROP_FIRST;
          else if (dv != 0) dec = sign_vote(dv);
          else if (dl != 0) dec = sign_vote(dl);
          else if (db != 0) dec = sign_vote(db);
          else dec = sign_vote(dc);
        end
      end
      v = '0;
      v.decision = dec;
      v.fake_level = (dec == cia_pkg::DEC_KEEP) ? 3'd0 : 3'(diff + 1);
      v.stop_scan = (dec == cia_pkg::DEC_MERGE || dec == cia_pkg::DEC_DROP_SECOND);
      return v;
    endfunction

    function void note_pair(pair_t p);
      verdict_q.push_back(judge(p));
    endfunction

    function void check_result(verdict_t got);
      verdict_t exp_v;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        fails++;
        return;
      end
      exp_v = verdict_q.pop_front();
      if (got.decision !== exp_v.decision) begin
        $display("%0t: decision expected %0d actual %0d", $time, exp_v.decision,
                 got.decision);
        fails++;
      end
      if (got.fake_level !== exp_v.fake_level) begin
        $display("%0t: fake_level expected %0d actual %0d", $time, exp_v.fake_level,
                 got.fake_level);
        fails++;
      end
      if (got.stop_scan !== exp_v.stop_scan) begin
        $display("%0t: stop_scan expected %0d actual %0d", $time, exp_v.stop_scan,
                 got.stop_scan);
        fails++;
      end
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  arbiter_scoreboard sb = new();
  bit steady = 1'b0;
  int ready_left = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  cluster_inclusion_arbiter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mostly short pauses, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pair_t make_pair(int c1, int c2, int l1, int l2, int b1, int b2,
                                      int v1, int v2, int sh);
    pair_t p;
    p = '0;
    p.cells_first = c1[8:0];
    p.cells_second = c2[8:0];
    p.layers_first = l1[4:0];
    p.layers_second = l2[4:0];
    p.bins_first = b1[15:0];
    p.bins_second = b2[15:0];
    p.level_first = v1[4:0];
    p.level_second = v2[4:0];
    p.shared_cells = sh[8:0];
    return p;
  endfunction

  // mostly near-duplicate pairs that pass the shared-cell gate
  function automatic pair_t random_pair();
    int pick, ms, c_small, c_big, delta, diff, sh, b1, b2, span, l1, l2, v1, v2, r;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      return make_pair($urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 24), $urandom_range(0, 24),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 511));
    ms = int'(sb.cfg.min_shared_cells);
    if (pick < 25) c_small = $urandom_range(0, 511);
    else c_small = $urandom_range(clamp(ms - 3, 511), ms + 40);
    r = $urandom_range(0, 9);
    if (r < 6) delta = $urandom_range(0, 12);
    else if (r < 9) delta = $urandom_range(0, 270);
    else delta = $urandom_range(0, 511);
    c_big = clamp(c_small + delta, 511);
    r = $urandom_range(0, 19);
    if (r < 4) diff = 0;
    else if (r < 18) diff = 1 + (r - 4) % 4;
    else if (r == 18) diff = $urandom_range(5, 8);
    else diff = -int'($urandom_range(1, 3));
    sh = clamp(c_small - diff, 511);
    b1 = $urandom_range(0, 65535);
    r = $urandom_range(0, 9);
    if (r < 2) b2 = b1;
    else if (r < 4) b2 = $urandom_range(0, 65535);
    else begin
      span = int'(sb.cfg.bin_margin) + 3;
      b2 = clamp(b1 + int'($urandom_range(0, 2 * span)) - span, 65535);
    end
    l1 = $urandom_range(0, 24);
    l2 = $urandom_range(0, 1) ? l1 : $urandom_range(0, 24);
    v1 = $urandom_range(0, 31);
    v2 = $urandom_range(0, 1) ? v1 : $urandom_range(0, 31);
    if ($urandom_range(0, 1))
      return make_pair(c_small, c_big, l1, l2, b1, b2, v1, v2, sh);
    return make_pair(c_big, c_small, l1, l2, b1, b2, v1, v2, sh);
  endfunction

  // accepted items, results, register writes and the stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_pair(pair_t'(s_tdata));
      if (m_tvalid && m_tready) sb.check_result(verdict_t'(m_tdata));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[cluster_inclusion_arbiter] ERROR");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (steady) begin
      m_tready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (m_tready) begin
      m_tready <= 1'b0;
      ready_left = idle_len();
    end else begin
      m_tready <= 1'b1;
      ready_left = $urandom_range(0, 30);
    end
  end

  task automatic send_pair(pair_t p);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= 80'(p);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the sender until every expected result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_cfg(logic [7:0] ms, logic [7:0] sl, logic [7:0] bm,
                           logic [7:0] m1, logic [7:0] m2, logic [7:0] m3,
                           logic [7:0] m4);
    write_reg(cia_pkg::REG_MIN_SHARED, ms);
    write_reg(cia_pkg::REG_SLACK, sl);
    write_reg(cia_pkg::REG_BIN_MARGIN, bm);
    write_reg(cia_pkg::REG_CELL_ONE, m1);
    write_reg(cia_pkg::REG_CELL_TWO, m2);
    write_reg(cia_pkg::REG_CELL_THREE, m3);
    write_reg(cia_pkg::REG_CELL_FOUR, m4);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 199) == 0) drain();
      send_pair(random_pair());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset margins: gate, every rung of both trees, boundaries
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(511, 511, 24, 24, 65535, 65535, 31, 31, 511));
    send_pair(make_pair(20, 10, 5, 5, 100, 50, 3, 3, 10));
    send_pair(make_pair(10, 20, 5, 5, 50, 100, 3, 3, 10));
    send_pair(make_pair(10, 10, 4, 4, 80, 80, 3, 7, 10));
    send_pair(make_pair(10, 10, 4, 4, 90, 80, 3, 3, 10));
    send_pair(make_pair(12, 10, 4, 4, 80, 80, 3, 3, 10));
    send_pair(make_pair(10, 12, 4, 4, 90, 80, 3, 3, 10));
    send_pair(make_pair(30, 20, 6, 6, 100, 10, 2, 2, 19));
    send_pair(make_pair(20, 30, 6, 6, 10, 100, 2, 2, 18));
    send_pair(make_pair(40, 40, 6, 6, 10, 10, 9, 4, 37));
    send_pair(make_pair(40, 40, 3, 8, 10, 10, 4, 4, 36));
    send_pair(make_pair(40, 40, 3, 3, 10, 11, 4, 4, 36));
    send_pair(make_pair(41, 40, 3, 3, 10, 10, 4, 4, 36));
    send_pair(make_pair(20, 20, 7, 7, 500, 500, 5, 5, 18));
    send_pair(make_pair(20, 20, 7, 7, 500, 900, 5, 5, 15));
    send_pair(make_pair(20, 20, 7, 7, 500, 900, 5, 5, 5));
    send_pair(make_pair(10, 12, 7, 7, 500, 900, 5, 5, 11));
    send_pair(make_pair(25, 21, 7, 7, 303, 300, 5, 5, 20));
    send_pair(make_pair(21, 26, 7, 7, 300, 297, 5, 5, 20));
    send_pair(make_pair(100, 511, 0, 24, 0, 65535, 0, 31, 96));
    send_pair(make_pair(511, 100, 24, 0, 65535, 0, 31, 0, 99));
    send_pair(make_pair(6, 6, 1, 1, 1, 1, 1, 1, 6));
    send_pair(make_pair(9, 9, 2, 2, 7, 7, 2, 2, 6));
    run_random(230);
    drain();

    // everything at zero
    apply_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    cfg_we <= 1'b0;
    run_random(236);
    drain();

    // everything at its top, slack written with spare upper bits
    apply_cfg(8'd255, 8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    cfg_we <= 1'b0;
    run_random(236);
    drain();

    // back to the reset margins, plus a write to the unused index
    apply_cfg(8'd6, 8'd2, 8'd2, 8'd4, 8'd6, 8'd7, 8'd8);
    write_reg(REG_UNUSED, 8'hA5);
    cfg_we <= 1'b0;
    steady = 1'b1;
    run_random(236);
    drain();
    steady = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      if (ph % 2 == 0)
        apply_cfg(8'($urandom_range(0, 20)), 8'($urandom_range(0, 15)),
                  8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                  8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                  8'($urandom_range(0, 10)));
      else
        apply_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      cfg_we <= 1'b0;
      run_random(236);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("[cluster_inclusion_arbiter] OK");
    end else begin
      $display("[cluster_inclusion_arbiter] ERROR");
    end
    $finish;
  end

endmodule
